// File: sv/planar_shadow_compare_blitter_core_assert.svh
// assertion macros for the checker file of the blitter core
// no dependencies; include by bare file name
`ifndef PLANAR_SHADOW_COMPARE_BLITTER_CORE_ASSERT_SVH
`define PLANAR_SHADOW_COMPARE_BLITTER_CORE_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define PSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("psc checker: same-cycle rule broken");

// next-cycle implication, off while reset is asserted
`define PSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("psc checker: next-cycle rule broken");

// next-cycle implication that also holds across reset
`define PSC_ASSERT_ALWAYS_NXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("psc checker: reset rule broken");

`endif

// File: sv/psc_pkg.sv
// shared types and constants of the planar shadow-compare blitter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

    localparam int SHADOW_WORDS  = 65536;
    localparam int MAX_ROW_WORDS = 64;
    localparam int MAX_ROWS      = 1024;
    localparam int NUM_PLANES    = 4;

    localparam int SHADOW_AW   = $clog2(SHADOW_WORDS);
    localparam int COL_W       = $clog2(MAX_ROW_WORDS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int PLANE_W     = $clog2(NUM_PLANES);

    localparam int WORD_W      = 32;
    localparam int ADDR_W      = 20;
    localparam int ROW_WORDS_W = 7;
    localparam int ROWS_W      = 11;
    localparam int GAP_W       = 12;
    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 2;

    localparam logic [ROW_WORDS_W-1:0] ROW_WORDS_RST = ROW_WORDS_W'(20);
    localparam logic [ROWS_W-1:0]      ROWS_RST      = ROWS_W'(480);
    localparam logic [GAP_W-1:0]       GAP_RST       = '0;

    localparam int RES_DEPTH = 8;
    localparam int RES_AW    = $clog2(RES_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_WORDS = 2'd0,
        CFG_ROWS      = 2'd1,
        CFG_LINE_GAP  = 2'd2
    } t_cfg_idx;

    localparam logic KIND_MASK  = 1'b0;
    localparam logic KIND_VIDEO = 1'b1;

    // one word as handed from the sequencer to the compare stage
    typedef struct packed {
        logic [SHADOW_AW-1:0]  idx;
        logic [ADDR_W-1:0]     addr;
        logic                  first;
        logic [NUM_PLANES-1:0] mask;
        logic                  filled;
    } t_issue;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] video_address;
        logic [WORD_W-1:0] value;
        logic              last;
    } t_res;

endpackage

`default_nettype wire

// File: sv/psc_in_if.sv
// request channel carrying source bit-plane words
// depends on psc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface psc_in_if;
    logic                       valid;
    logic                       ready;
    logic [psc_pkg::WORD_W-1:0] pixel_word;

    modport source (output valid, output pixel_word, input ready);
    modport sink   (input valid, input pixel_word, output ready);
endinterface

`default_nettype wire

// File: sv/psc_out_if.sv
// request channel carrying plane-mask and video writes
// depends on psc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface psc_out_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [psc_pkg::ADDR_W-1:0] video_address;
    logic [psc_pkg::WORD_W-1:0] value;
    logic                       last;

    modport source (output valid, output kind, output video_address, output value,
                    output last, input ready);
    modport sink   (input valid, input kind, input video_address, input value,
                    input last, output ready);
endinterface

`default_nettype wire

// File: sv/psc_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module psc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: sv/psc_seq.sv
// configuration registers, plane/row/column counters and shadow fill count
// depends on psc_pkg
`timescale 1ns / 1ps
`default_nettype none

module psc_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [psc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [psc_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                          i_adv,
    output psc_pkg::t_issue                    o_iss
);

    logic [psc_pkg::ROW_WORDS_W-1:0] r_row_words;
    logic [psc_pkg::ROWS_W-1:0]      r_rows;
    logic [psc_pkg::GAP_W-1:0]       r_gap;

    logic [psc_pkg::PLANE_W-1:0]     r_plane, n_plane;
    logic [psc_pkg::ROW_W-1:0]       r_row, n_row;
    logic [psc_pkg::COL_W-1:0]       r_col, n_col;
    logic [psc_pkg::SHADOW_AW-1:0]   r_idx, n_idx;
    logic [psc_pkg::ADDR_W-1:0]      r_off, n_off;
    logic [psc_pkg::SHADOW_AW:0]     r_fill, n_fill;

    logic [psc_pkg::ROW_WORDS_W-1:0] rw_eff;
    logic [psc_pkg::ROWS_W-1:0]      nr_eff;
    logic                            col_end;
    logic                            row_end;

    // clamp registers to their legal ranges
    always_comb begin
        if (r_row_words == '0) begin
            rw_eff = psc_pkg::ROW_WORDS_W'(1);
        end else if (r_row_words > psc_pkg::ROW_WORDS_W'(psc_pkg::MAX_ROW_WORDS)) begin
            rw_eff = psc_pkg::ROW_WORDS_W'(psc_pkg::MAX_ROW_WORDS);
        end else begin
            rw_eff = r_row_words;
        end
        if (r_rows == '0) begin
            nr_eff = psc_pkg::ROWS_W'(1);
        end else if (r_rows > psc_pkg::ROWS_W'(psc_pkg::MAX_ROWS)) begin
            nr_eff = psc_pkg::ROWS_W'(psc_pkg::MAX_ROWS);
        end else begin
            nr_eff = r_rows;
        end
    end

    assign col_end = (psc_pkg::ROW_WORDS_W'(r_col) + psc_pkg::ROW_WORDS_W'(1)) >= rw_eff;
    assign row_end = (psc_pkg::ROWS_W'(r_row) + psc_pkg::ROWS_W'(1)) >= nr_eff;

    always_comb begin
        n_col   = r_col + psc_pkg::COL_W'(1);
        n_row   = r_row;
        n_plane = r_plane;
        n_idx   = r_idx + psc_pkg::SHADOW_AW'(1);
        n_off   = r_off + psc_pkg::ADDR_W'(1);
        if (col_end) begin
            n_col = '0;
            n_row = r_row + psc_pkg::ROW_W'(1);
            n_off = r_off + psc_pkg::ADDR_W'(1) + psc_pkg::ADDR_W'(r_gap >> 2);
            if (row_end) begin
                n_row   = '0;
                n_off   = '0;
                n_plane = r_plane + psc_pkg::PLANE_W'(1);
                if (r_plane == psc_pkg::PLANE_W'(psc_pkg::NUM_PLANES - 1)) begin
                    n_idx = '0;
                end
            end
        end
        // entries are visited in order from zero, so a high-water mark
        // tells which ones have been written since reset
        n_fill = r_fill;
        if ({1'b0, r_idx} == r_fill &&
            r_fill != (psc_pkg::SHADOW_AW+1)'(psc_pkg::SHADOW_WORDS)) begin
            n_fill = r_fill + (psc_pkg::SHADOW_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_words <= psc_pkg::ROW_WORDS_RST;
            r_rows      <= psc_pkg::ROWS_RST;
            r_gap       <= psc_pkg::GAP_RST;
            r_plane     <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_idx       <= '0;
            r_off       <= '0;
            r_fill      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    psc_pkg::CFG_ROW_WORDS: begin
                        r_row_words <= i_cfg_wdata[psc_pkg::ROW_WORDS_W-1:0];
                    end
                    psc_pkg::CFG_ROWS: begin
                        r_rows <= i_cfg_wdata[psc_pkg::ROWS_W-1:0];
                    end
                    psc_pkg::CFG_LINE_GAP: begin
                        r_gap <= i_cfg_wdata[psc_pkg::GAP_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_adv) begin
                r_plane <= n_plane;
                r_row   <= n_row;
                r_col   <= n_col;
                r_idx   <= n_idx;
                r_off   <= n_off;
                r_fill  <= n_fill;
            end
        end
    end

    assign o_iss.idx    = r_idx;
    assign o_iss.addr   = r_off;
    assign o_iss.first  = (r_row == '0) && (r_col == '0);
    assign o_iss.mask   = psc_pkg::NUM_PLANES'(1) << r_plane;
    assign o_iss.filled = {1'b0, r_idx} < r_fill;

endmodule

`default_nettype wire

// File: sv/psc_res_fifo.sv
// result queue taking up to two results per cycle, one out per cycle while popped
// depends on psc_pkg
`timescale 1ns / 1ps
`default_nettype none

module psc_res_fifo (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_wr0,
    input  wire psc_pkg::t_res              i_d0,
    input  wire logic                       i_wr1,
    input  wire psc_pkg::t_res              i_d1,
    input  wire logic                       i_pop,
    output logic                            o_valid,
    output psc_pkg::t_res                   o_head,
    output logic [psc_pkg::RES_AW:0]        o_count
);

    psc_pkg::t_res                r_mem [psc_pkg::RES_DEPTH];
    logic [psc_pkg::RES_AW-1:0]   r_wp;
    logic [psc_pkg::RES_AW-1:0]   r_rp;
    logic [psc_pkg::RES_AW:0]     r_cnt;
    logic [psc_pkg::RES_AW-1:0]   wp1;
    logic                         pop_ok;

    assign wp1    = r_wp + psc_pkg::RES_AW'(1);
    assign pop_ok = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (i_wr0) begin
            r_mem[r_wp] <= i_d0;
        end
        if (i_wr1) begin
            r_mem[wp1] <= i_d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + psc_pkg::RES_AW'(i_wr0) + psc_pkg::RES_AW'(i_wr1);
            r_rp  <= r_rp + psc_pkg::RES_AW'(pop_ok);
            r_cnt <= r_cnt + (psc_pkg::RES_AW+1)'(i_wr0) + (psc_pkg::RES_AW+1)'(i_wr1)
                     - (psc_pkg::RES_AW+1)'(pop_ok);
        end
    end

    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rp];
    assign o_count = r_cnt;

endmodule

`default_nettype wire

// File: sv/planar_shadow_compare_blitter_core.sv
// an accepted word is registered in the compare stage; its results then enter the result queue
// throughput: one word per cycle if ready; plane's first word may give two results; output bounds it
// output moves one result per cycle while ready; input waits when the result queue lacks room
// reset: synchronous active-low, clears counters, queue and the shadow fill count
// no clearing pass: shadow entries past the fill count read as zero
`timescale 1ns / 1ps
`default_nettype none

module planar_shadow_compare_blitter_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    psc_in_if.sink                             i_pix,
    psc_out_if.source                          o_res,
    input  wire logic                          i_cfg_we,
    input  wire logic [psc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [psc_pkg::CFG_W-1:0]     i_cfg_wdata
);

    // sequencer output for the word at the input
    psc_pkg::t_issue              iss;
    logic                         accept;

    // compare stage registers
    logic                         r_s1_vld;
    psc_pkg::t_issue              r_s1;
    logic [psc_pkg::WORD_W-1:0]   r_s1_word;
    logic                         r_s1_fwd;
    logic [psc_pkg::WORD_W-1:0]   r_s1_fwd_word;

    logic [psc_pkg::WORD_W-1:0]   ram_q;
    logic [psc_pkg::WORD_W-1:0]   old_word;
    logic                         diff;

    psc_pkg::t_res                res0;
    psc_pkg::t_res                res1;
    logic                         wr0;
    logic                         wr1;

    psc_pkg::t_res                head;
    logic                         head_vld;
    logic [psc_pkg::RES_AW:0]     q_cnt;
    logic [psc_pkg::RES_AW:0]     q_free;

    // keep room for two results of the word in the compare stage plus
    // two of the word being accepted
    assign q_free      = (psc_pkg::RES_AW+1)'(psc_pkg::RES_DEPTH) - q_cnt;
    assign i_pix.ready = r_s1_vld ? (q_free >= (psc_pkg::RES_AW+1)'(4))
                                  : (q_free >= (psc_pkg::RES_AW+1)'(2));
    assign accept      = i_pix.valid && i_pix.ready;

    psc_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_adv       (accept),
        .o_iss       (iss)
    );

    // shadow frame: read at accept, written back in the following cycle
    psc_ram #(
        .WIDTH (psc_pkg::WORD_W),
        .DEPTH (psc_pkg::SHADOW_WORDS)
    ) u_shadow (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1.idx),
        .i_wdata (r_s1_word),
        .i_raddr (iss.idx),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
    end

    // payload of the compare stage; forward the word written this cycle
    // when the new read hits the same entry
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1          <= iss;
            r_s1_word     <= i_pix.pixel_word;
            r_s1_fwd      <= r_s1_vld && (r_s1.idx == iss.idx);
            r_s1_fwd_word <= r_s1_word;
        end
    end

    // entries never written read as the reset value zero
    always_comb begin
        if (r_s1_fwd) begin
            old_word = r_s1_fwd_word;
        end else if (r_s1.filled) begin
            old_word = ram_q;
        end else begin
            old_word = '0;
        end
    end

    assign diff = old_word != r_s1_word;

    // build up to two results; the plane mask write comes first
    always_comb begin
        res1.kind          = psc_pkg::KIND_VIDEO;
        res1.video_address = r_s1.addr;
        res1.value         = r_s1_word;
        res1.last          = 1'b1;
        if (r_s1.first) begin
            res0.kind          = psc_pkg::KIND_MASK;
            res0.video_address = '0;
            res0.value         = psc_pkg::WORD_W'(r_s1.mask);
            res0.last          = !diff;
        end else begin
            res0 = res1;
        end
    end

    assign wr0 = r_s1_vld && (r_s1.first || diff);
    assign wr1 = r_s1_vld && r_s1.first && diff;

    psc_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr0   (wr0),
        .i_d0    (res0),
        .i_wr1   (wr1),
        .i_d1    (res1),
        .i_pop   (o_res.ready),
        .o_valid (head_vld),
        .o_head  (head),
        .o_count (q_cnt)
    );

    assign o_res.valid         = head_vld;
    assign o_res.kind          = head.kind;
    assign o_res.video_address = head.video_address;
    assign o_res.value         = head.value;
    assign o_res.last          = head.last;

endmodule

`default_nettype wire

// File: sv/psc_checker.sv
// port-level checks of the blitter core, bound to the top level
// depends on psc_pkg and planar_shadow_compare_blitter_core_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "planar_shadow_compare_blitter_core_assert.svh"

module psc_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_res_valid,
    input wire logic                        i_res_ready,
    input wire logic                        i_res_kind,
    input wire logic [psc_pkg::ADDR_W-1:0]  i_res_addr,
    input wire logic [psc_pkg::WORD_W-1:0]  i_res_value,
    input wire logic                        i_res_last
);

    logic mask_vld;
    logic mask_form_ok;
    logic mask_open;
    logic video_vld;

    assign mask_vld     = i_res_valid && (i_res_kind == psc_pkg::KIND_MASK);
    assign mask_form_ok = (i_res_addr == '0) && $onehot(i_res_value) &&
                          (i_res_value[psc_pkg::WORD_W-1:psc_pkg::NUM_PLANES] == '0);
    assign mask_open    = mask_vld && i_res_ready && !i_res_last;
    assign video_vld    = i_res_valid && (i_res_kind == psc_pkg::KIND_VIDEO);

    // a stalled request stays offered
    `PSC_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid)

    // plane mask writes carry address zero and a single plane bit
    `PSC_ASSERT_IMP(a_mask_form, i_clk, i_rst_n, mask_vld, mask_form_ok)

    // a mask write that is not last is followed at once by its video write
    `PSC_ASSERT_NXT(a_mask_pair, i_clk, i_rst_n, mask_open, video_vld)

    // reset empties the output
    `PSC_ASSERT_ALWAYS_NXT(a_rst_empty, i_clk, !i_rst_n, !i_res_valid)

endmodule

bind planar_shadow_compare_blitter_core psc_checker u_psc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_kind  (o_res.kind),
    .i_res_addr  (o_res.video_address),
    .i_res_value (o_res.value),
    .i_res_last  (o_res.last)
);

`default_nettype wire
